>>> design/rkgd_pkg.sv
// Package for the rotary knob gesture decoder: widths, gesture codes and the
// tangent table used by the angle search. No dependencies.
`default_nettype none

package rkgd_pkg;

    localparam int MAG_W  = 16;
    localparam int TAN_W  = 34;
    localparam int PROD_W = MAG_W + TAN_W;
    localparam int FLR_W  = 7;
    localparam int ANG_W  = 9;

    localparam logic [TAN_W-1:0] TAN_SCALE = 34'd10000000000;

    localparam logic [2:0] G_UP        = 3'd0;
    localparam logic [2:0] G_DOWN      = 3'd1;
    localparam logic [2:0] G_LIFT      = 3'd2;
    localparam logic [2:0] G_LIFT_REST = 3'd3;
    localparam logic [2:0] G_PRESS     = 3'd4;
    localparam logic [2:0] G_REST      = 3'd5;
    localparam logic [2:0] G_NONE      = 3'd6;

    localparam logic CFG_PRESS_THR = 1'b0;
    localparam logic CFG_TURN_THR  = 1'b1;

    typedef logic [MAG_W-1:0]  t_mag;
    typedef logic [TAN_W-1:0]  t_tan;
    typedef logic [PROD_W-1:0] t_prod;

    // Tangent of whole degrees 0 to 45 in units of 1e-10, rounded to nearest.
    function automatic t_tan tan_deg(input logic [5:0] deg);
        t_tan t;
        case (deg)
            6'd1:  t = 34'd174550649;
            6'd2:  t = 34'd349207695;
            6'd3:  t = 34'd524077793;
            6'd4:  t = 34'd699268119;
            6'd5:  t = 34'd874886635;
            6'd6:  t = 34'd1051042353;
            6'd7:  t = 34'd1227845609;
            6'd8:  t = 34'd1405408347;
            6'd9:  t = 34'd1583844403;
            6'd10: t = 34'd1763269807;
            6'd11: t = 34'd1943803091;
            6'd12: t = 34'd2125565617;
            6'd13: t = 34'd2308681911;
            6'd14: t = 34'd2493280028;
            6'd15: t = 34'd2679491924;
            6'd16: t = 34'd2867453858;
            6'd17: t = 34'd3057306815;
            6'd18: t = 34'd3249196962;
            6'd19: t = 34'd3443276133;
            6'd20: t = 34'd3639702343;
            6'd21: t = 34'd3838640350;
            6'd22: t = 34'd4040262258;
            6'd23: t = 34'd4244748162;
            6'd24: t = 34'd4452286853;
            6'd25: t = 34'd4663076582;
            6'd26: t = 34'd4877325886;
            6'd27: t = 34'd5095254495;
            6'd28: t = 34'd5317094317;
            6'd29: t = 34'd5543090515;
            6'd30: t = 34'd5773502692;
            6'd31: t = 34'd6008606190;
            6'd32: t = 34'd6248693519;
            6'd33: t = 34'd6494075932;
            6'd34: t = 34'd6745085168;
            6'd35: t = 34'd7002075382;
            6'd36: t = 34'd7265425280;
            6'd37: t = 34'd7535540501;
            6'd38: t = 34'd7812856265;
            6'd39: t = 34'd8097840332;
            6'd40: t = 34'd8390996312;
            6'd41: t = 34'd8692867378;
            6'd42: t = 34'd9004040443;
            6'd43: t = 34'd9325150861;
            6'd44: t = 34'd9656887748;
            6'd45: t = TAN_SCALE;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

>>> design/rotary_knob_gesture_decoder.sv
// Rotary knob gesture decoder: input and output channels, configuration
// registers, the sequencer and the decision logic. Depends on rkgd_pkg and
// instantiates rkgd_mult.
//
// The input channel (i_in_valid, o_in_ready) carries one sensor sample per
// transaction: a command bit and the raw X and Y words. A classify command
// yields one gesture transaction on the output channel (o_out_valid,
// i_out_ready); a set-reference command yields none and only stores the angle.
// The angle is found by a binary search over whole degrees in seven steps; a
// step compares two products from one shared multiplier in the states S_MUL_L,
// S_MUL_R and S_CMP, or ends in S_MUL_L when the candidate degree needs no
// products. The squared magnitude reuses the same multiplier. A set-reference
// stores its angle in S_ANGLE, and a classify places its result in the output
// register in S_DECIDE after S_SQX, S_SQY and S_SUM. One sample is in work at
// a time; o_in_ready is high while the sequencer is idle, even when a result
// still waits in the output register. When the receiver stalls, the next
// classify holds before its decision until the output register is free. Reset
// clears the reference angle to zero, the last gesture to none and the
// thresholds to their default values.
// Configuration writes are taken at any edge with i_cfg_we high outside reset.
`default_nettype none

module rotary_knob_gesture_decoder (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_idx,
    input  wire [31:0] i_cfg_wdata,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire        i_cmd,
    input  wire [15:0] i_x_word,
    input  wire [15:0] i_y_word,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic [2:0] o_gesture
);
    import rkgd_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MUL_L  = 9'b000000010,
        S_MUL_R  = 9'b000000100,
        S_CMP    = 9'b000001000,
        S_ANGLE  = 9'b000010000,
        S_SQX    = 9'b000100000,
        S_SQY    = 9'b001000000,
        S_SUM    = 9'b010000000,
        S_DECIDE = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [31:0]             r_press_thr;
    logic [7:0]              r_turn_thr;
    logic signed [ANG_W-1:0] r_ref;
    logic signed [ANG_W-1:0] r_ang;
    logic [2:0]              r_prev;
    logic                    r_out_valid;
    logic [2:0]              r_gesture;

    logic             r_cmd;
    logic             r_xneg;
    logic             r_yneg;
    t_mag             r_a;
    t_mag             r_b;
    logic [FLR_W-1:0] r_floor;
    logic             r_eq;
    logic [2:0]       r_bit;
    t_prod            r_lhs;
    logic [31:0]      r_m;

    logic [15:0] x_v, y_v;
    t_mag        in_a, in_b;
    t_prod       prod;
    t_mag        op_a;
    t_tan        op_b;
    t_tan        tan_v;

    logic [FLR_W-1:0] cand;
    logic             cand_lo;
    logic [5:0]       tan_idx;
    logic             last_bit;
    logic             accept;
    logic             commit;

    logic [FLR_W-1:0]        ceil_v;
    logic [ANG_W-1:0]        mag_v;
    logic signed [ANG_W-1:0] ang_c;

    logic signed [9:0] diff, diff2, thr_s;
    logic              turn_up, turn_down;
    logic [2:0]        gest_c;

    assign x_v  = {i_x_word[13:0], 2'b00};
    assign y_v  = {i_y_word[13:0], 2'b00};
    assign in_a = x_v[15] ? t_mag'(~x_v + 16'd1) : x_v;
    assign in_b = y_v[15] ? t_mag'(~y_v + 16'd1) : y_v;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    assign cand     = r_floor | (FLR_W'(1) << r_bit);
    assign cand_lo  = (cand <= 7'd45);
    assign tan_idx  = cand_lo ? cand[5:0] : 6'(7'd90 - cand);
    assign tan_v    = tan_deg(tan_idx);
    assign last_bit = (r_bit == 3'd0);

    always_comb begin
        op_a = r_a;
        op_b = t_tan'(r_a);
        case (r_state)
            S_MUL_L: begin
                op_a = r_b;
                op_b = cand_lo ? TAN_SCALE : tan_v;
            end
            S_MUL_R: begin
                op_a = r_a;
                op_b = cand_lo ? tan_v : TAN_SCALE;
            end
            S_SQY: begin
                op_a = r_b;
                op_b = t_tan'(r_b);
            end
            default: begin
                op_a = r_a;
                op_b = t_tan'(r_a);
            end
        endcase
    end

    rkgd_mult u_mult (
        .i_clk  (i_clk),
        .i_op_a (op_a),
        .i_op_b (op_b),
        .o_prod (prod)
    );

    assign ceil_v = r_eq ? r_floor : r_floor + 7'd1;
    assign mag_v  = r_xneg ? 9'd180 - ANG_W'(ceil_v) : ANG_W'(r_floor);

    always_comb begin
        if (r_a == '0 && r_b == '0) begin
            ang_c = '0;
        end else if (r_yneg) begin
            ang_c = -$signed(mag_v);
        end else begin
            ang_c = $signed(mag_v);
        end
    end

    assign diff  = 10'(r_ang) - 10'(r_ref);
    assign thr_s = $signed({2'b00, r_turn_thr});

    always_comb begin
        if (diff > 10'sd180) begin
            diff2 = diff - 10'sd360;
        end else if (diff < -10'sd180) begin
            diff2 = diff + 10'sd360;
        end else begin
            diff2 = diff;
        end
    end

    assign turn_up   = (diff2 > thr_s) && (diff2 < 10'sd180);
    assign turn_down = (diff2 < -thr_s) && (diff2 > -10'sd180);

    always_comb begin
        if (turn_up) begin
            gest_c = G_UP;
        end else if (turn_down) begin
            gest_c = G_DOWN;
        end else if (r_m > r_press_thr) begin
            gest_c = (r_prev == G_REST) ? G_LIFT_REST : G_LIFT;
        end else if (r_m < r_press_thr) begin
            gest_c = (r_prev == G_LIFT || r_prev == G_LIFT_REST) ? G_PRESS : G_REST;
        end else begin
            gest_c = G_REST;
        end
    end

    assign commit = (r_state == S_DECIDE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_MUL_L;
            end
            S_MUL_L: begin
                if (cand >= 7'd90) begin
                    n_state = last_bit ? S_ANGLE : S_MUL_L;
                end else begin
                    n_state = S_MUL_R;
                end
            end
            S_MUL_R: n_state = S_CMP;
            S_CMP: begin
                n_state = last_bit ? S_ANGLE : S_MUL_L;
            end
            S_ANGLE: begin
                n_state = r_cmd ? S_IDLE : S_SQX;
            end
            S_SQX: n_state = S_SQY;
            S_SQY: n_state = S_SUM;
            S_SUM: n_state = S_DECIDE;
            S_DECIDE: begin
                if (commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_press_thr <= 32'd30000000;
            r_turn_thr  <= 8'd18;
            r_ref       <= '0;
            r_prev      <= G_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PRESS_THR) begin
                    r_press_thr <= i_cfg_wdata;
                end else begin
                    r_turn_thr <= i_cfg_wdata[7:0];
                end
            end
            if (r_state == S_ANGLE && r_cmd) begin
                r_ref <= ang_c;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
                r_prev      <= gest_c;
                if (gest_c != G_REST) begin
                    r_ref <= r_ang;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_xneg  <= x_v[15];
            r_yneg  <= y_v[15];
            r_a     <= in_a;
            r_b     <= in_b;
            r_floor <= '0;
            r_eq    <= (in_b == '0);
            r_bit   <= 3'd6;
        end
        unique case (r_state)
            S_MUL_L: begin
                if (cand >= 7'd90) begin
                    if (cand == 7'd90 && r_a == '0) begin
                        r_floor <= cand;
                        r_eq    <= 1'b1;
                    end
                    r_bit <= r_bit - 3'd1;
                end
            end
            S_MUL_R: r_lhs <= prod;
            S_CMP: begin
                if (r_lhs >= prod) begin
                    r_floor <= cand;
                    r_eq    <= (r_lhs == prod);
                end
                r_bit <= r_bit - 3'd1;
            end
            S_ANGLE: r_ang <= ang_c;
            S_SQY:   r_m <= prod[31:0];
            S_SUM:   r_m <= r_m + prod[31:0];
            default: ;
        endcase
        if (commit) begin
            r_gesture <= gest_c;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_gesture   = r_gesture;

    a_floor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ANGLE) |-> (r_floor <= 7'd90))
        else $error("angle search left the degree range");

    a_ang_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQX) |-> (r_ang >= -9'sd180 && r_ang <= 9'sd180))
        else $error("computed angle out of range");

    a_ref_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ref >= -9'sd180 && r_ref <= 9'sd180))
        else $error("reference angle out of range");

    a_out_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DECIDE))
        else $error("result raised outside the decision step");

    a_no_result_for_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ANGLE && r_cmd) |=> (r_state == S_IDLE))
        else $error("set-reference transaction went on to classification");

endmodule

`default_nettype wire

>>> design/rkgd_mult.sv
// Shared multiplier of the gesture decoder with a registered product.
// Depends on rkgd_pkg.
`default_nettype none

module rkgd_mult (
    input  wire            i_clk,
    input  rkgd_pkg::t_mag i_op_a,
    input  rkgd_pkg::t_tan i_op_b,
    output rkgd_pkg::t_prod o_prod
);
    import rkgd_pkg::*;

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= t_prod'(i_op_a) * t_prod'(i_op_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> verif/rotary_knob_gesture_decoder_test.sv
// Self-checking testbench for rotary_knob_gesture_decoder: queued sensor samples,
// a clocked driver and monitor, and a bit-exact gesture predictor.
// Depends on rkgd_pkg and the decoder RTL only.
module rotary_knob_gesture_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rkgd_pkg::*;

    localparam logic CMD_CLASSIFY = 1'b0;
    localparam logic CMD_SET_REF  = 1'b1;
    localparam int   SETTLE_CYCLES = 40;
    localparam int   CYCLE_LIMIT   = 1000000;
    localparam int   PHASES        = 8;
    localparam int   PHASE_ITEMS   = 200;

    typedef struct packed {
        logic        cmd;
        logic [15:0] x_word;
        logic [15:0] y_word;
    } knob_sample_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_idx   = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_in_valid  = 1'b0;
    logic        i_cmd       = 1'b0;
    logic [15:0] i_x_word    = '0;
    logic [15:0] i_y_word    = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_gesture;

    rotary_knob_gesture_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_x_word    (i_x_word),
        .i_y_word    (i_y_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_gesture   (o_gesture)
    );

    always #4 i_clk = ~i_clk;

    knob_sample_t samples_pending[$];
    logic [2:0]   gestures_due[$];

    // Predictor state and its copy of the configuration registers.
    int          ref_deg      = 0;
    logic [2:0]  last_gesture = G_NONE;
    logic [31:0] press_limit  = 32'd30000000;
    int          turn_limit   = 18;

    int unsigned cycle_count = 0;
    int          mismatches  = 0;
    logic        in_fire     = 1'b0;
    logic [2:0]  due_gesture;
    knob_sample_t sample_now;
    int          burst_left  = 0;
    int          idle_left   = 0;
    int          stall_left  = 0;
    int          walk_x      = 4000;
    int          walk_y      = 0;

    function automatic longint unsigned tan_e10(int d);
        case (d)
            1:  return 64'd174550649;
            2:  return 64'd349207695;
            3:  return 64'd524077793;
            4:  return 64'd699268119;
            5:  return 64'd874886635;
            6:  return 64'd1051042353;
            7:  return 64'd1227845609;
            8:  return 64'd1405408347;
            9:  return 64'd1583844403;
            10: return 64'd1763269807;
            11: return 64'd1943803091;
            12: return 64'd2125565617;
            13: return 64'd2308681911;
            14: return 64'd2493280028;
            15: return 64'd2679491924;
            16: return 64'd2867453858;
            17: return 64'd3057306815;
            18: return 64'd3249196962;
            19: return 64'd3443276133;
            20: return 64'd3639702343;
            21: return 64'd3838640350;
            22: return 64'd4040262258;
            23: return 64'd4244748162;
            24: return 64'd4452286853;
            25: return 64'd4663076582;
            26: return 64'd4877325886;
            27: return 64'd5095254495;
            28: return 64'd5317094317;
            29: return 64'd5543090515;
            30: return 64'd5773502692;
            31: return 64'd6008606190;
            32: return 64'd6248693519;
            33: return 64'd6494075932;
            34: return 64'd6745085168;
            35: return 64'd7002075382;
            36: return 64'd7265425280;
            37: return 64'd7535540501;
            38: return 64'd7812856265;
            39: return 64'd8097840332;
            40: return 64'd8390996312;
            41: return 64'd8692867378;
            42: return 64'd9004040443;
            43: return 64'd9325150861;
            44: return 64'd9656887748;
            45: return 64'd10000000000;
            default: return 64'd0;
        endcase
    endfunction

    // Sign of (atan(b/a) - d) in the first quadrant.
    function automatic int degree_order(longint unsigned a, longint unsigned b, int d);
        longint unsigned lhs, rhs;
        if (d <= 0) begin
            return (b > 0) ? 1 : 0;
        end
        if (d >= 90) begin
            return (a > 0) ? -1 : 0;
        end
        if (d <= 45) begin
            lhs = b * 64'd10000000000;
            rhs = a * tan_e10(d);
        end else begin
            lhs = b * tan_e10(90 - d);
            rhs = a * 64'd10000000000;
        end
        return (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
    endfunction

    function automatic int sensor_value(logic [15:0] w);
        logic signed [15:0] v;
        v = {w[13:0], 2'b00};
        return int'(v);
    endfunction

    function automatic int knob_angle(int x, int y);
        longint unsigned a, b;
        int fl, ce, d, deg;
        a = (x < 0) ? -x : x;
        b = (y < 0) ? -y : y;
        if (a == 0 && b == 0) begin
            return 0;
        end
        fl = 0;
        ce = 0;
        for (d = 1; d <= 90; d++) begin
            if (degree_order(a, b, d) >= 0) fl++;
        end
        for (d = 0; d <= 89; d++) begin
            if (degree_order(a, b, d) > 0) ce++;
        end
        deg = (x >= 0) ? fl : 180 - ce;
        return (y >= 0) ? deg : -deg;
    endfunction

    task automatic predict_sample(logic cmd, logic [15:0] xw, logic [15:0] yw);
        int x, y, ang, adj, diff;
        logic [31:0] mag2;
        logic [2:0] g;
        x = sensor_value(xw);
        y = sensor_value(yw);
        ang = knob_angle(x, y);
        if (cmd == CMD_SET_REF) begin
            ref_deg = ang;
        end else begin
            diff = ang - ref_deg;
            adj = ang;
            if (diff > 180) begin
                adj = ang - 360;
            end else if (diff < -180) begin
                adj = ang + 360;
            end
            diff = adj - ref_deg;
            mag2 = 32'(x * x + y * y);
            if (diff > turn_limit && diff < 180) begin
                g = G_UP;
            end else if (diff < -turn_limit && diff > -180) begin
                g = G_DOWN;
            end else if (mag2 > press_limit) begin
                g = (last_gesture == G_REST) ? G_LIFT_REST : G_LIFT;
            end else if (mag2 < press_limit) begin
                g = (last_gesture == G_LIFT || last_gesture == G_LIFT_REST) ? G_PRESS : G_REST;
            end else begin
                g = G_REST;
            end
            if (g != G_REST) ref_deg = ang;
            last_gesture = g;
            gestures_due.push_back(g);
        end
    endtask

    task automatic report_mismatch(string what, logic [2:0] got, logic [2:0] want);
        mismatches++;
        if (mismatches <= 100) begin
            $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (gestures_due.size() == 0) begin
                report_mismatch("gesture transaction with none pending", o_gesture, G_NONE);
            end else begin
                due_gesture = gestures_due.pop_front();
                if (o_gesture !== due_gesture) begin
                    report_mismatch("gesture field", o_gesture, due_gesture);
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_sample(i_cmd, i_x_word, i_y_word);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (idle_left > 0) begin
                idle_left = idle_left - 1;
                i_in_valid <= 1'b0;
            end else if (samples_pending.size() != 0) begin
                sample_now = samples_pending.pop_front();
                i_cmd <= sample_now.cmd;
                i_x_word <= sample_now.x_word;
                i_y_word <= sample_now.y_word;
                i_in_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end else begin
                    burst_left = burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (cycle_count[11:10] != 2'd0 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, (cycle_count[11:10] == 2'd1) ? 6 : 60);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic int fit_sensor(int v);
        if (v > 32764) return 32764;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic logic [15:0] word_of(int v);
        logic [15:0] w;
        w[13:0] = v[15:2];
        w[15:14] = 2'($urandom_range(0, 3));
        return w;
    endfunction

    task automatic queue_sample(logic cmd, int x, int y);
        samples_pending.push_back({cmd, word_of(x), word_of(y)});
    endtask

    task automatic queue_random(int count);
        int n, kind, s;
        logic cmd;
        logic [15:0] rx, ry;
        for (n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            cmd = ($urandom_range(0, 4) == 0) ? CMD_SET_REF : CMD_CLASSIFY;
            if (kind == 0) begin
                walk_x = int'($urandom_range(0, 65535)) - 32768;
                walk_y = int'($urandom_range(0, 65535)) - 32768;
                queue_sample(cmd, walk_x, walk_y);
            end else if (kind < 6) begin
                // Stay near the last direction and vary the field strength.
                s = $urandom_range(0, 5);
                if ($urandom_range(0, 1) == 1) begin
                    walk_x = walk_x >>> s;
                    walk_y = walk_y >>> s;
                end else begin
                    walk_x = walk_x <<< s;
                    walk_y = walk_y <<< s;
                end
                walk_x = fit_sensor(walk_x + int'($urandom_range(0, 80)) - 40);
                walk_y = fit_sensor(walk_y + int'($urandom_range(0, 80)) - 40);
                queue_sample(cmd, walk_x, walk_y);
            end else if (kind < 9) begin
                rx = 16'($urandom());
                ry = 16'($urandom());
                samples_pending.push_back({cmd, rx, ry});
            end else begin
                case ($urandom_range(0, 4))
                    0: queue_sample(cmd, 0, 0);
                    1: queue_sample(cmd, -32768, -32768);
                    2: queue_sample(cmd, 32764, 32764);
                    3: queue_sample(cmd, -32768, 0);
                    default: queue_sample(cmd, 0, 32764);
                endcase
            end
        end
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (samples_pending.size() != 0 || i_in_valid || gestures_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PRESS_THR) begin
            press_limit = data;
        end else begin
            turn_limit = int'(data[7:0]);
        end
    endtask

    initial begin : stimulus
        logic [31:0] press_set [PHASES];
        logic [31:0] turn_set [PHASES];
        int p;
        press_set = '{32'd0, 32'h8000_0000, 32'hFFFF_FFFF, 32'd30000000,
                      32'($urandom_range(0, 2000000)), 32'($urandom_range(0, 32'h8000_0000)),
                      32'd1, 32'($urandom_range(0, 200000000))};
        turn_set = '{32'd0, 32'd179, 32'd255, 32'd18,
                     32'($urandom_range(0, 179)), 32'($urandom_range(0, 255)),
                     32'd1, 32'd90};
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples at the reset thresholds.
        queue_sample(CMD_CLASSIFY, 0, 0);
        queue_sample(CMD_CLASSIFY, 32764, 0);
        queue_sample(CMD_CLASSIFY, 400, 0);
        queue_sample(CMD_CLASSIFY, 0, 8000);
        queue_sample(CMD_CLASSIFY, 8000, 0);
        queue_sample(CMD_SET_REF, -8000, 0);
        queue_sample(CMD_CLASSIFY, -32768, -32768);
        queue_sample(CMD_CLASSIFY, 8000, -8000);
        queue_sample(CMD_CLASSIFY, -4, 0);
        queue_sample(CMD_CLASSIFY, 0, 0);
        queue_sample(CMD_CLASSIFY, 0, -4);
        queue_sample(CMD_CLASSIFY, 4, -400);
        queue_sample(CMD_CLASSIFY, 32764, 32764);
        queue_sample(CMD_CLASSIFY, -32768, 32764);
        queue_sample(CMD_CLASSIFY, 32764, -32768);
        queue_sample(CMD_SET_REF, 0, 0);
        queue_sample(CMD_CLASSIFY, 100, 4);
        queue_sample(CMD_CLASSIFY, 4000, 1300);
        queue_sample(CMD_CLASSIFY, 4000, 1320);
        samples_pending.push_back({CMD_CLASSIFY, 16'hFFFF, 16'h0000});
        samples_pending.push_back({CMD_CLASSIFY, 16'h0000, 16'hFFFF});
        samples_pending.push_back({CMD_SET_REF, 16'h5555, 16'hAAAA});
        samples_pending.push_back({CMD_CLASSIFY, 16'hAAAA, 16'h5555});

        for (p = 0; p < PHASES; p++) begin
            wait_drained();
            write_reg(CFG_PRESS_THR, press_set[p]);
            write_reg(CFG_TURN_THR, turn_set[p]);
            queue_random(PHASE_ITEMS);
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/rkgd_pkg.sv
design/rkgd_mult.sv
design/rotary_knob_gesture_decoder.sv
verif/rotary_knob_gesture_decoder_test.sv
